/* rtl/core/mmms_pkg.sv */
// mmms_pkg: item types, status and mode codes, and empty-stack constants
// for the min/max/middle stack. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mmms_pkg;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

  localparam logic signed [31:0] EMPTY_LOWEST  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] EMPTY_HIGHEST = 32'sh8000_0000;
  localparam logic signed [31:0] UNDERFLOW_POP = -32'sd1;

  typedef struct packed {
    logic              mode;
    logic signed [31:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic [1:0]         status;
    logic [7:0]         entry_count;
    logic signed [31:0] lowest_entry;
    logic signed [31:0] highest_entry;
    logic signed [31:0] middle_entry;
  } out_item_t;

  // One stack slot: the word and the running min/max of it and all below.
  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] run_min;
    logic signed [31:0] run_max;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/mmms_cell.sv */
// mmms_cell: one stack slot. Takes the slot above on push, the slot below
// on pop, holds otherwise. Depends on mmms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmms_cell (
  input  wire logic                clk,
  input  wire mmms_pkg::shift_ctl_t ctl,
  input  wire mmms_pkg::entry_t    from_above,
  input  wire mmms_pkg::entry_t    from_below,
  output mmms_pkg::entry_t         entry
);

  mmms_pkg::entry_t entry_r;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      entry_r <= from_above;
    end else if (ctl.pop) begin
      entry_r <= from_below;
    end
  end

  assign entry = entry_r;

endmodule

`default_nettype wire

/* rtl/core/mmms_mid_sel.sv */
// mmms_mid_sel: two-step select of the slot value at a given depth.
// Groups are picked into registers, then one group output is chosen.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mmms_mid_sel #(
  parameter int STACK_DEPTH = 128
) (
  input  wire logic                      clk,
  input  wire logic                      load,
  input  wire logic signed [31:0]        vals [STACK_DEPTH],
  input  wire logic [$clog2(STACK_DEPTH)-1:0] idx,
  output logic signed [31:0]             mid
);

  localparam int IDX_W = $clog2(STACK_DEPTH);
  localparam int LO_W  = (IDX_W + 1) / 2;
  localparam int HI_W  = (IDX_W > 1) ? (IDX_W - LO_W) : 1;
  localparam int GSZ   = 2 ** LO_W;
  localparam int NGRP  = 2 ** HI_W;

  logic signed [31:0] blk   [NGRP][GSZ];
  logic signed [31:0] grp_r [NGRP];
  logic [LO_W+HI_W-1:0] idx_x;
  logic [LO_W-1:0]      idx_lo;
  logic [HI_W-1:0]      idx_hi_r;

  assign idx_x  = (LO_W + HI_W)'(idx);
  assign idx_lo = idx_x[LO_W-1:0];

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    for (genvar k = 0; k < GSZ; k++) begin : g_slot
      if (g * GSZ + k < STACK_DEPTH) begin : g_real
        assign blk[g][k] = vals[g * GSZ + k];
      end else begin : g_pad
        assign blk[g][k] = '0;
      end
    end

    always_ff @(posedge clk) begin
      if (load) begin
        grp_r[g] <= blk[g][idx_lo];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      idx_hi_r <= idx_x[LO_W+HI_W-1:LO_W];
    end
  end

  assign mid = grp_r[idx_hi_r];

endmodule

`default_nettype wire

/* rtl/core/min_max_mid_stack.sv */
// min_max_mid_stack: top level. Chain of mmms_cell slots plus mmms_mid_sel.
// Depends on mmms_pkg, mmms_cell, mmms_mid_sel.
//
// Bounded stack of signed 32-bit words held in a row of shift cells, top
// slot first; each slot also carries the running min and max of itself and
// everything below, so lowest and highest come straight from the top slot.
// An item is taken when start is high and busy is low, and its result
// appears on out_item with out_strobe high for exactly one cycle, once the
// chain shift, group pick and final choice are all registered; the receiver
// cannot stall it. A new item may be started in the cycle the strobe is
// high. Each item shifts the chain, then picks the group holding the middle
// slot, then chooses within it and registers the result.
`timescale 1ns / 1ps
`default_nettype none

module min_max_mid_stack #(
  parameter int STACK_DEPTH = 128
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire mmms_pkg::in_item_t  in_item,
  output logic                     out_strobe,
  output mmms_pkg::out_item_t      out_item
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SEL  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_strobe_r;
  logic signed [31:0] popped_r, popped_nxt;
  logic [1:0]       status_r, status_nxt;
  mmms_pkg::out_item_t out_item_r;

  mmms_pkg::entry_t     cell_q [STACK_DEPTH];
  mmms_pkg::entry_t     new_top;
  mmms_pkg::shift_ctl_t ctl;
  logic signed [31:0]   vals [STACK_DEPTH];
  logic signed [31:0]   mid;
  logic [IDX_W-1:0]     mid_idx;
  logic [31:0]          cnt_ext;
  logic                 accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    ctl        = '0;
    count_nxt  = count_r;
    popped_nxt = popped_r;
    status_nxt = status_r;
    if (accept) begin
      if (in_item.mode == mmms_pkg::MODE_PUSH) begin
        popped_nxt = '0;
        if (count_r >= FULL_CNT) begin
          status_nxt = mmms_pkg::STAT_OVERFLOW;
        end else begin
          status_nxt = mmms_pkg::STAT_OK;
          ctl.push   = 1'b1;
          count_nxt  = count_r + 1'b1;
        end
      end else begin
        if (count_r == '0) begin
          popped_nxt = mmms_pkg::UNDERFLOW_POP;
          status_nxt = mmms_pkg::STAT_UNDERFLOW;
        end else begin
          popped_nxt = cell_q[0].value;
          status_nxt = mmms_pkg::STAT_OK;
          ctl.pop    = 1'b1;
          count_nxt  = count_r - 1'b1;
        end
      end
    end
  end

  always_comb begin
    new_top.value   = in_item.push_value;
    new_top.run_min = in_item.push_value;
    new_top.run_max = in_item.push_value;
    if (count_r != '0) begin
      if (cell_q[0].run_min < in_item.push_value) begin
        new_top.run_min = cell_q[0].run_min;
      end
      if (in_item.push_value < cell_q[0].run_max) begin
        new_top.run_max = cell_q[0].run_max;
      end
    end
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    mmms_pkg::entry_t above, below;
    if (i == 0) begin : g_top
      assign above = new_top;
    end else begin : g_mid
      assign above = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = '0;
    end else begin : g_up
      assign below = cell_q[i+1];
    end

    mmms_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .from_above (above),
      .from_below (below),
      .entry      (cell_q[i])
    );

    assign vals[i] = cell_q[i].value;
  end

  assign mid_idx = IDX_W'(count_r >> 1);

  mmms_mid_sel #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_mid_sel (
    .clk  (clk),
    .load (state_r == S_SEL),
    .vals (vals),
    .idx  (mid_idx),
    .mid  (mid)
  );

  always_comb begin
    case (state_r)
      S_IDLE:  state_nxt = accept ? S_SEL : S_IDLE;
      S_SEL:   state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= (state_r == S_OUT);
    end
  end

  assign cnt_ext = 32'(count_r);

  always_ff @(posedge clk) begin
    popped_r <= popped_nxt;
    status_r <= status_nxt;
    if (state_r == S_OUT) begin
      out_item_r.popped_value <= popped_r;
      out_item_r.status       <= status_r;
      out_item_r.entry_count  <= cnt_ext[7:0];
      if (count_r == '0) begin
        out_item_r.lowest_entry  <= mmms_pkg::EMPTY_LOWEST;
        out_item_r.highest_entry <= mmms_pkg::EMPTY_HIGHEST;
        out_item_r.middle_entry  <= '0;
      end else begin
        out_item_r.lowest_entry  <= cell_q[0].run_min;
        out_item_r.highest_entry <= cell_q[0].run_max;
        out_item_r.middle_entry  <= mid;
      end
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

`default_nettype wire
